>>> rtl/core/crt_pkg.sv
// Shared types, widths, op codes and the per-sample micro-op table
// of the Catmull-Rom tessellator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int CRD_W           = 18;
    localparam int T_W             = 16;
    localparam int STEP_W          = 16;
    localparam int TDATA_W         = 56;
    localparam int ACC_W           = 44;
    localparam int PROD_W          = 48;
    localparam int OPND_W          = 25;
    localparam int DM_W            = 23;
    localparam int RAD_W           = 48;
    localparam int ROOT_W          = 24;
    localparam int DIVR_W          = 20;
    localparam int QUO_W           = 32;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    localparam logic [3:0] PC_AXIS = 4'd4;
    localparam logic [3:0] PC_LAST = 4'd12;

    // multiplier operand selection
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_TT   = 4'd1;
    localparam logic [3:0] MUL_T2T  = 4'd2;
    localparam logic [3:0] MUL_BT   = 4'd3;
    localparam logic [3:0] MUL_CT   = 4'd4;
    localparam logic [3:0] MUL_CT2  = 4'd5;
    localparam logic [3:0] MUL_DT2  = 4'd6;
    localparam logic [3:0] MUL_DT3  = 4'd7;
    localparam logic [3:0] MUL_DM   = 4'd8;

    // use of the registered product
    localparam logic [3:0] ACC_NONE  = 4'd0;
    localparam logic [3:0] ACC_CLR_S = 4'd1;
    localparam logic [3:0] ACC_T2    = 4'd2;
    localparam logic [3:0] ACC_T3    = 4'd3;
    localparam logic [3:0] ACC_INIT  = 4'd4;
    localparam logic [3:0] ACC_P     = 4'd5;
    localparam logic [3:0] ACC_D2    = 4'd6;
    localparam logic [3:0] ACC_D3    = 4'd7;
    localparam logic [3:0] ACC_ROUND = 4'd8;
    localparam logic [3:0] ACC_S     = 4'd9;

    typedef struct packed {
        logic [3:0] mul;
        logic [3:0] acc;
    } crt_uop_t;

    typedef struct packed {
        logic       load;
        logic [3:0] mul;
        logic [3:0] acc;
        logic [1:0] axis;
        logic       sqrt1_go;
        logic       sqrt2_go;
        logic       div_go;
        logic       emit;
        logic       last;
        logic       trunc;
        logic       adv_t;
    } crt_cmd_t;

    typedef struct packed {
        logic seg_go;
        logic sqrt_done;
        logic div_done;
        logic s_zero;
        logic reach_one;
        logic out_free;
    } crt_sts_t;

    function automatic crt_uop_t crt_uop(input logic [3:0] pc);
        crt_uop_t u;
        u.mul = MUL_NONE;
        u.acc = ACC_NONE;
        case (pc)
            4'd0:  begin u.mul = MUL_TT;  u.acc = ACC_CLR_S; end
            4'd1:  begin u.acc = ACC_T2; end
            4'd2:  begin u.mul = MUL_T2T; end
            4'd3:  begin u.acc = ACC_T3; end
            4'd4:  begin u.mul = MUL_BT;  u.acc = ACC_INIT; end
            4'd5:  begin u.mul = MUL_CT;  u.acc = ACC_P; end
            4'd6:  begin u.mul = MUL_CT2; u.acc = ACC_D2; end
            4'd7:  begin u.mul = MUL_DT2; u.acc = ACC_P; end
            4'd8:  begin u.mul = MUL_DT3; u.acc = ACC_D3; end
            4'd9:  begin u.acc = ACC_P; end
            4'd10: begin u.acc = ACC_ROUND; end
            4'd11: begin u.mul = MUL_DM; end
            4'd12: begin u.acc = ACC_S; end
            default: begin end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/crt_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_isqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [crt_pkg::RAD_W-1:0]  radicand,
    output logic                           done,
    output logic [crt_pkg::ROOT_W-1:0]     root
);
    import crt_pkg::*;

    localparam logic [4:0] ITER_LAST = 5'(ROOT_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              ge;
    logic [ROOT_W+3:0] rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            root_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            cnt_reg  <= cnt_reg + 5'd1;
            if (cnt_reg == ITER_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> rtl/core/crt_udiv.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_udiv (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [crt_pkg::QUO_W-1:0]  dividend,
    input  wire logic [crt_pkg::DIVR_W-1:0] divisor,
    output logic                            done,
    output logic [crt_pkg::QUO_W-1:0]       quotient
);
    import crt_pkg::*;

    localparam logic [4:0] ITER_LAST = 5'(QUO_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [QUO_W-1:0]  dvd_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIVR_W-1:0] rem_reg;

    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W:0]   rem_sub;
    logic              ge;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[QUO_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[QUO_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == ITER_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

>>> rtl/core/crt_datapath.sv
// Datapath: point window, coefficients, shared multiplier, accumulators,
// root and divide units, step register and output register. Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    input  wire logic [crt_pkg::STEP_W-1:0]  cfg_data,
    input  wire logic [crt_pkg::TDATA_W-1:0] s_tdata,
    input  wire logic                        s_tuser,
    input  wire crt_pkg::crt_cmd_t           cmd,
    output crt_pkg::crt_sts_t                sts,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [crt_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);
    import crt_pkg::*;

    logic [STEP_W-1:0]       step_reg;
    logic signed [CRD_W-1:0] win_reg [9];
    logic [1:0]              held_reg;
    logic                    seg_go_reg;

    logic signed [18:0]      a_reg [3];
    logic signed [18:0]      b_reg [3];
    logic signed [21:0]      c_reg [3];
    logic signed [20:0]      d_reg [3];

    logic [T_W-1:0]          t_reg, t2_reg, t3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] pacc_reg, dacc_reg;
    logic [RAD_W-1:0]        sacc_reg;
    logic [DM_W-1:0]         dm_reg;
    logic signed [CRD_W-1:0] smp_reg [3];

    logic                    mv_reg;
    logic [TDATA_W-1:0]      md_reg;
    logic                    ml_reg, mu_reg;

    logic signed [CRD_W-1:0] p3 [3];
    logic [1:0]              held_eff;
    logic signed [OPND_W-1:0] opa, opb;
    logic signed [ACC_W-1:0] pmag, dmag;
    logic [ACC_W-1:0]        pr_w, dr_w;
    logic [26:0]             pr, dr;
    logic signed [CRD_W-1:0] smp_val;
    logic [T_W+16:0]         tsq_rnd;
    logic                    sq_done, dv_done;
    logic [ROOT_W-1:0]       root;
    logic [QUO_W-1:0]        quo;
    logic [QUO_W-1:0]        delta;
    logic [QUO_W:0]          t_sum;

    assign p3[0]    = s_tdata[17:0];
    assign p3[1]    = s_tdata[35:18];
    assign p3[2]    = s_tdata[53:36];
    assign held_eff = s_tuser ? 2'd0 : held_reg;

    always_comb begin
        opa = '0;
        opb = '0;
        case (cmd.mul)
            MUL_TT:  begin opa = OPND_W'(t_reg);  opb = OPND_W'(t_reg); end
            MUL_T2T: begin opa = OPND_W'(t2_reg); opb = OPND_W'(t_reg); end
            MUL_BT:  begin opa = OPND_W'(b_reg[cmd.axis]); opb = OPND_W'(t_reg); end
            MUL_CT:  begin opa = OPND_W'(c_reg[cmd.axis]); opb = OPND_W'(t_reg); end
            MUL_CT2: begin opa = OPND_W'(c_reg[cmd.axis]); opb = OPND_W'(t2_reg); end
            MUL_DT2: begin opa = OPND_W'(d_reg[cmd.axis]); opb = OPND_W'(t2_reg); end
            MUL_DT3: begin opa = OPND_W'(d_reg[cmd.axis]); opb = OPND_W'(t3_reg); end
            MUL_DM:  begin opa = OPND_W'(dm_reg); opb = OPND_W'(dm_reg); end
            default: begin end
        endcase
    end

    // round half away from zero by 2^17
    always_comb begin
        pmag = pacc_reg[ACC_W-1] ? -pacc_reg : pacc_reg;
        dmag = dacc_reg[ACC_W-1] ? -dacc_reg : dacc_reg;
        pr_w = (pmag + ACC_W'(65536)) >> 17;
        dr_w = (dmag + ACC_W'(65536)) >> 17;
        pr   = pr_w[26:0];
        dr   = dr_w[26:0];
        if (!pacc_reg[ACC_W-1]) begin
            smp_val = (pr > 27'd131071) ? 18'sh1FFFF : pr[17:0];
        end else begin
            smp_val = (pr > 27'd131072) ? 18'sh20000 : (~pr[17:0] + 18'd1);
        end
        tsq_rnd = prod_reg[T_W+16:0] + (T_W+17)'(32768);
    end

    crt_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt1_go | cmd.sqrt2_go),
        .radicand (cmd.sqrt1_go ? sacc_reg : {8'd0, root, 16'd0}),
        .done     (sq_done),
        .root     (root)
    );

    crt_udiv u_udiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend ({step_reg, 16'd0}),
        .divisor  (root[DIVR_W-1:0]),
        .done     (dv_done),
        .quotient (quo)
    );

    assign delta = (quo == '0) ? QUO_W'(1) : quo;
    assign t_sum = {1'b0, delta} + (QUO_W+1)'(t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= STEP_RESET;
            held_reg   <= '0;
            seg_go_reg <= 1'b0;
            mv_reg     <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            if (cfg_valid) step_reg <= cfg_data;
            if (cmd.load) begin
                if (held_eff == 2'd3) begin
                    seg_go_reg <= 1'b1;
                    for (int ax = 0; ax < 3; ax++) begin
                        a_reg[ax] <= 19'(win_reg[3+ax]) <<< 1;
                        b_reg[ax] <= 19'(win_reg[6+ax]) - 19'(win_reg[ax]);
                        c_reg[ax] <= (22'(win_reg[ax]) <<< 1) - 22'(win_reg[3+ax]) * 22'sd5
                                   + (22'(win_reg[6+ax]) <<< 2) - 22'(p3[ax]);
                        d_reg[ax] <= 21'(win_reg[3+ax]) * 21'sd3 - 21'(win_reg[ax])
                                   - 21'(win_reg[6+ax]) * 21'sd3 + 21'(p3[ax]);
                        win_reg[ax]   <= win_reg[3+ax];
                        win_reg[3+ax] <= win_reg[6+ax];
                        win_reg[6+ax] <= p3[ax];
                    end
                end else begin
                    seg_go_reg <= 1'b0;
                    held_reg   <= held_eff + 2'd1;
                    for (int k = 0; k < 3; k++) begin
                        if (held_eff == 2'(k)) begin
                            for (int ax = 0; ax < 3; ax++) win_reg[3*k+ax] <= p3[ax];
                        end
                    end
                end
            end
            if (cmd.emit) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(opa * opb);
        case (cmd.acc)
            ACC_CLR_S: sacc_reg <= '0;
            ACC_T2:    t2_reg <= tsq_rnd[T_W+15:16];
            ACC_T3:    t3_reg <= tsq_rnd[T_W+15:16];
            ACC_INIT: begin
                pacc_reg <= ACC_W'(a_reg[cmd.axis]) <<< 16;
                dacc_reg <= ACC_W'(b_reg[cmd.axis]) <<< 16;
            end
            ACC_P:     pacc_reg <= pacc_reg + prod_reg[ACC_W-1:0];
            ACC_D2:    dacc_reg <= dacc_reg + (prod_reg[ACC_W-1:0] <<< 1);
            ACC_D3:    dacc_reg <= dacc_reg + prod_reg[ACC_W-1:0]
                                   + (prod_reg[ACC_W-1:0] <<< 1);
            ACC_ROUND: begin
                smp_reg[cmd.axis] <= smp_val;
                dm_reg            <= dr[DM_W-1:0];
            end
            ACC_S:     sacc_reg <= sacc_reg + prod_reg;
            default: begin end
        endcase
        if (cmd.load) begin
            t_reg <= '0;
        end else if (cmd.adv_t) begin
            t_reg <= t_reg + delta[T_W-1:0];
        end
        if (cmd.emit) begin
            md_reg <= {2'b00, smp_reg[2], smp_reg[1], smp_reg[0]};
            ml_reg <= cmd.last;
            mu_reg <= cmd.trunc;
        end
    end

    always_comb begin
        sts.seg_go    = seg_go_reg;
        sts.sqrt_done = sq_done;
        sts.div_done  = dv_done;
        sts.s_zero    = (root == '0);
        sts.reach_one = (t_sum >= (QUO_W+1)'(65536));
        sts.out_free  = !mv_reg || m_tready;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

endmodule

`default_nettype wire

>>> rtl/core/crt_ctrl.sv
// Controller: sequences the per-sample micro-ops, the root and divide
// units, the stop decision and output hand-off. Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_ctrl #(
    parameter int MAX_SAMPLES = crt_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire crt_pkg::crt_sts_t sts,
    output crt_pkg::crt_cmd_t      cmd
);
    import crt_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CHECK    = 4'd1;
    localparam logic [3:0] ST_CALC     = 4'd2;
    localparam logic [3:0] ST_SQ1_GO   = 4'd3;
    localparam logic [3:0] ST_SQ1_WAIT = 4'd4;
    localparam logic [3:0] ST_SQ2_GO   = 4'd5;
    localparam logic [3:0] ST_SQ2_WAIT = 4'd6;
    localparam logic [3:0] ST_DIV_GO   = 4'd7;
    localparam logic [3:0] ST_DIV_WAIT = 4'd8;
    localparam logic [3:0] ST_EMIT     = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [3:0]       pc_reg, pc_next;
    logic [1:0]       axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             trunc_reg, trunc_next;
    crt_uop_t         uop;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        trunc_next = trunc_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_tready   = 1'b0;
        uop        = crt_uop(pc_reg);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                pc_next   = '0;
                axis_next = '0;
                cnt_next  = '0;
                state_next = sts.seg_go ? ST_CALC : ST_IDLE;
            end
            ST_CALC: begin
                cmd.mul = uop.mul;
                cmd.acc = uop.acc;
                if (pc_reg == PC_LAST) begin
                    if (axis_reg == 2'd2) begin
                        state_next = ST_SQ1_GO;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                        pc_next   = PC_AXIS;
                    end
                end else begin
                    pc_next = pc_reg + 4'd1;
                end
            end
            ST_SQ1_GO: begin
                cmd.sqrt1_go = 1'b1;
                state_next   = ST_SQ1_WAIT;
            end
            ST_SQ1_WAIT: begin
                if (sts.sqrt_done) state_next = ST_SQ2_GO;
            end
            ST_SQ2_GO: begin
                cmd.sqrt2_go = 1'b1;
                state_next   = ST_SQ2_WAIT;
            end
            ST_SQ2_WAIT: begin
                if (sts.sqrt_done) begin
                    if (sts.s_zero) begin
                        last_next  = 1'b1;
                        trunc_next = 1'b0;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO: begin
                cmd.div_go = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_EMIT;
                    if (sts.reach_one) begin
                        last_next  = 1'b1;
                        trunc_next = 1'b0;
                    end else if (cnt_reg + CNT_W'(1) >= CNT_W'(MAX_SAMPLES)) begin
                        last_next  = 1'b1;
                        trunc_next = 1'b1;
                    end else begin
                        last_next  = 1'b0;
                        trunc_next = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.last  = last_reg;
                    cmd.trunc = trunc_reg;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.adv_t  = 1'b1;
                        pc_next    = '0;
                        axis_next  = '0;
                        state_next = ST_CALC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            axis_reg  <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            trunc_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            trunc_reg <= trunc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/catmull_rom_adaptive_tessellator.sv
// Adaptive Catmull-Rom tessellator, top level.
// Joins crt_ctrl and crt_datapath; depends on crt_pkg.
//
// Usage:
//   s_ channel: one control point per item; new_path on s_tuser restarts the
//   window. From the fourth point of a path, each item yields the samples of
//   the segment between the two middle points of the window on the m_
//   channel; m_tlast marks the last sample, m_tuser the sample-limit stop.
//   cfg channel: writes step_length at any handshake; cfg_ready is always high.
// Timing:
//   One item is in work at a time; s_tready is high only when idle. Each
//   sample runs the shared multiplier sequence, the two square roots, the
//   divide and the hand-off in that order; a sample with zero derivative
//   skips the divide.
// Reset: aresetn low clears the window, point count, step_length (655) and
//   the output valid flag.
// Stall: a pending sample sits in the output register; the next sample waits
//   until it is taken, and a new item is accepted while the last one waits.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_adaptive_tessellator #(
    parameter int MAX_SAMPLES = crt_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [crt_pkg::STEP_W-1:0]  cfg_data,    // step_length
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [crt_pkg::TDATA_W-1:0] s_tdata,     // point_x, point_y, point_z
    input  wire logic                        s_tuser,     // new_path
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [crt_pkg::TDATA_W-1:0]      m_tdata,     // sample_x, sample_y, sample_z
    output logic                             m_tlast,     // segment_end
    output logic                             m_tuser      // truncated
);
    import crt_pkg::*;

    crt_cmd_t cmd;
    crt_sts_t sts;

    assign cfg_ready = 1'b1;

    crt_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> bench/crt_checker.sv
// Sample checker for the Catmull-Rom tessellator: watches the point, sample and
// step_length channels, predicts every sample and compares. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_checker #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [crt_pkg::STEP_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [crt_pkg::TDATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [crt_pkg::TDATA_W-1:0] m_tdata,
    input  logic                        m_tlast,
    input  logic                        m_tuser,
    output int                          fail_count,
    output int                          samples_pending
);
    typedef struct packed {
        logic [17:0] z;
        logic [17:0] y;
        logic [17:0] x;
        logic        seg_end;
        logic        trunc;
    } sample_t;

    sample_t     sample_q[$];
    logic [15:0] step_len;
    longint      win[9];
    int          held;

    assign samples_pending = sample_q.size();

    function automatic longint round_shift(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [17:0] clamp18(longint v);
        if (v > 131071) return 18'h1FFFF;
        if (v < -131072) return 18'h20000;
        return v[17:0];
    endfunction

    task automatic tessellate(logic [crt_pkg::TDATA_W-1:0] data, logic restart);
        longint p3[3];
        longint ca[3], cb[3], cc[3], cd[3];
        longint t, t2, t3, pn, dn, dq, sumsq, s, delta;
        int cnt;
        sample_t smp;
        bit done;
        for (int a = 0; a < 3; a++) p3[a] = longint'($signed(data[a*18 +: 18]));
        if (restart) held = 0;
        if (held >= 3) begin
            for (int a = 0; a < 3; a++) begin
                ca[a] = 2 * win[3+a];
                cb[a] = win[6+a] - win[a];
                cc[a] = 2 * win[a] - 5 * win[3+a] + 4 * win[6+a] - p3[a];
                cd[a] = -win[a] + 3 * win[3+a] - 3 * win[6+a] + p3[a];
            end
            t = 0;
            cnt = 0;
            done = 0;
            while (!done) begin
                t2 = (t * t + 32768) >>> 16;
                t3 = (t2 * t + 32768) >>> 16;
                sumsq = 0;
                for (int a = 0; a < 3; a++) begin
                    pn = ca[a] * 65536 + cb[a] * t + cc[a] * t2 + cd[a] * t3;
                    dn = cb[a] * 65536 + 2 * cc[a] * t + 3 * cd[a] * t2;
                    dq = round_shift(dn, 17);
                    if (dq < 0) dq = -dq;
                    sumsq += dq * dq;
                    case (a)
                        0: smp.x = clamp18(round_shift(pn, 17));
                        1: smp.y = clamp18(round_shift(pn, 17));
                        default: smp.z = clamp18(round_shift(pn, 17));
                    endcase
                end
                cnt++;
                smp.seg_end = 0;
                smp.trunc = 0;
                s = int_sqrt(int_sqrt(sumsq) <<< 16);
                if (s == 0) begin
                    smp.seg_end = 1;
                end else begin
                    delta = (longint'(step_len) <<< 16) / s;
                    if (delta == 0) delta = 1;
                    if (t + delta >= 65536) smp.seg_end = 1;
                    else if (cnt >= MAX_SAMPLES) begin
                        smp.seg_end = 1;
                        smp.trunc = 1;
                    end else t += delta;
                end
                sample_q.insert(sample_q.size(), smp);
                done = smp.seg_end;
            end
            for (int i = 0; i < 6; i++) win[i] = win[i+3];
            for (int a = 0; a < 3; a++) win[6+a] = p3[a];
        end else begin
            for (int a = 0; a < 3; a++) win[3*held+a] = p3[a];
            held++;
        end
    endtask

    always @(posedge aclk) begin
        sample_t got;
        sample_t want;
        if (!aresetn) begin
            step_len <= crt_pkg::STEP_RESET;
            held = 0;
            for (int i = 0; i < 9; i++) win[i] = 0;
            sample_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) step_len <= cfg_data;
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[17:0];
                got.y = m_tdata[35:18];
                got.z = m_tdata[53:36];
                got.seg_end = m_tlast;
                got.trunc = m_tuser;
                if (sample_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected sample x=%0d y=%0d z=%0d", $signed(got.x),
                                 $signed(got.y), $signed(got.z));
                    fail_count <= fail_count + 1;
                end else begin
                    want = sample_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("sample mismatch: exp %0d %0d %0d last %b trunc %b, ",
                                     $signed(want.x), $signed(want.y), $signed(want.z),
                                     want.seg_end, want.trunc,
                                     "got %0d %0d %0d last %b trunc %b",
                                     $signed(got.x), $signed(got.y), $signed(got.z),
                                     got.seg_end, got.trunc);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) tessellate(s_tdata, s_tuser);
        end
    end
endmodule

>>> bench/catmull_rom_adaptive_tessellator_tb.sv
// Testbench top for the Catmull-Rom tessellator: drives control points and
// step_length settings with random gaps and stalls; crt_checker does the checking.
`timescale 1ns / 1ps

module catmull_rom_adaptive_tessellator_tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic [15:0] cfg_data = 0;
    logic        s_tvalid = 0;
    logic [55:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tready = 0;
    logic        cfg_ready, s_tready, m_tvalid, m_tlast, m_tuser;
    logic [55:0] m_tdata;
    int          fail_count, samples_pending;
    bit          sender_done = 0;

    always #1 aclk = ~aclk;

    catmull_rom_adaptive_tessellator dut (.*);

    crt_checker chk (.*);

    // s_tvalid stays high after the accepting edge until the next falling edge
    task automatic send_point(logic [17:0] x, logic [17:0] y, logic [17:0] z, logic np);
        int w;
        w = $urandom_range(0, 14);
        @(negedge aclk);
        if (w != 0) begin
            s_tvalid <= 0;
            repeat (w) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, z, y, x};
        s_tuser <= np;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_all();
        @(negedge aclk);
        s_tvalid <= 0;
        while (samples_pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic set_step(logic [15:0] v);
        drain_all();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic logic [17:0] small_coord();
        return 18'($signed($urandom_range(0, 8000)) - 4000);
    endfunction

    task automatic random_path(int n);
        logic [17:0] c[3];
        for (int a = 0; a < 3; a++) c[a] = small_coord() * 8;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_point(18'($urandom), 18'($urandom), 18'($urandom),
                           1'($urandom_range(0, 1)));
            end else begin
                for (int a = 0; a < 3; a++) c[a] = c[a] + small_coord();
                send_point(c[0], c[1], c[2], i == 0);
            end
        end
    endtask

    initial begin
        int w;
        forever begin
            w = $urandom_range(0, 14);
            if (w != 0) begin
                m_tready <= 0;
                repeat (w) @(negedge aclk);
            end else begin
                @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: extremes, zero derivative, saturation, new path mid-window
        send_point(18'h1FFFF, 18'h20000, 0, 0);
        send_point(18'h20000, 18'h1FFFF, 18'h3FFFF, 0);
        send_point(18'h1FFFF, 18'h20000, 18'h1FFFF, 0);
        send_point(18'h20000, 18'h1FFFF, 18'h20000, 0);
        send_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0);
        send_point(5, 5, 5, 1);
        send_point(5, 5, 5, 0);
        send_point(5, 5, 5, 0);
        send_point(5, 5, 5, 0);
        set_step(16'd1);
        send_point(0, 0, 0, 1);
        send_point(100, 0, 0, 0);
        send_point(200, 0, 0, 0);
        send_point(300, 0, 0, 0);
        set_step(16'hFFFF);
        send_point(18'h2AAAA, 18'h15555, 0, 0);
        send_point(18'h15555, 18'h2AAAA, 18'h3FFFF, 0);
        send_point(0, 0, 18'h20000, 0);
        set_step(16'd40);
        send_point(0, 0, 0, 1);
        send_point(65536, 0, 0, 0);
        send_point(0, 65536, 0, 0);
        send_point(0, 0, 65536, 0);
        drain_all();
        set_step(16'd655);
        random_path(90);
        set_step(16'd3000);
        random_path(90);
        set_step(16'($urandom_range(200, 20000)));
        random_path(60);
        set_step(16'd655);
        random_path(50);
        drain_all();
        sender_done = 1;
    end

    initial begin
        wait (sender_done);
        if (fail_count == 0)
            $display("PASS catmull_rom_adaptive_tessellator");
        else
            $display("FAIL catmull_rom_adaptive_tessellator");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("FAIL catmull_rom_adaptive_tessellator");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/crt_pkg.sv
rtl/core/crt_isqrt.sv
rtl/core/crt_udiv.sv
rtl/core/crt_datapath.sv
rtl/core/crt_ctrl.sv
rtl/core/catmull_rom_adaptive_tessellator.sv
bench/crt_checker.sv
bench/catmull_rom_adaptive_tessellator_tb.sv
